/* rtl/lnc_pkg.sv */
`default_nettype none

package lnc_pkg;

	// fixed field widths of the ports
	localparam int unsigned NODE_W  = 16;
	localparam int unsigned TOTAL_W = 5;
	localparam int unsigned LIMIT_W = 5;

	localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TOUCH,
		ST_TRIM
	} lnc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_id;     // latch node_id on an input beat
		logic touch;       // match and reorder the list
		logic evict;       // drop the tail, send an eviction beat
		logic emit_final;  // send the single no-eviction beat
	} lnc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // output register can take a beat this cycle
		logic over_limit;  // count above limit
		logic last_evict;  // dropping one more entry reaches the limit
	} lnc_sts_t;

endpackage : lnc_pkg

`default_nettype wire

/* rtl/lnc_ctrl.sv */
`default_nettype none

module lnc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire lnc_pkg::lnc_sts_t sts,
	output lnc_pkg::lnc_cmd_t      cmd
);
	import lnc_pkg::*;

	lnc_state_t state_q;
	lnc_state_t state_d;
	logic       done;   // final beat of the current item goes out now
	logic       take;   // input beat accepted now

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// final beat: last eviction, or the no-eviction beat
	always_comb begin
		done = 1'b0;
		if (state_q == ST_TRIM && sts.out_free) begin
			done = sts.over_limit ? sts.last_evict : 1'b1;
		end
	end

	assign take = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) state_d = ST_TOUCH;
			end
			ST_TOUCH: begin
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				if (done) state_d = take ? ST_TOUCH : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_TOUCH: begin
				cmd.touch = 1'b1;
			end
			ST_TRIM: begin
				in_stall = !done;
				if (sts.out_free) begin
					cmd.evict      = sts.over_limit;
					cmd.emit_final = !sts.over_limit;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		cmd.load_id = in_valid && !in_stall;
	end

endmodule : lnc_ctrl

`default_nettype wire

/* rtl/lnc_dpath.sv */
`default_nettype none

module lnc_dpath #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned ID_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [lnc_pkg::LIMIT_W-1:0]    cfg_data,
	input  wire logic [lnc_pkg::NODE_W-1:0]     node_id,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                newly_referenced,
	output logic                                evict_valid,
	output logic [lnc_pkg::NODE_W-1:0]          evicted_node,
	output logic [lnc_pkg::TOTAL_W-1:0]         entry_total,
	output logic                                last,
	input  wire lnc_pkg::lnc_cmd_t              cmd,
	output lnc_pkg::lnc_sts_t                   sts
);
	import lnc_pkg::*;

	localparam int unsigned SLOTS = CAPACITY + 1;
	localparam int unsigned CW    = $clog2(SLOTS + 1);           // count width
	localparam int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned MW    = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

	// list cells, slot 0 is most recent; slots below count_q are listed
	logic [ID_BITS-1:0] tag_q [SLOTS];
	logic [CW-1:0]      count_q;
	logic [LIMIT_W-1:0] max_entries_q;
	logic [ID_BITS-1:0] id_q;
	logic               nref_q;

	logic               out_valid_q;
	logic               nref_out_q;
	logic               evict_valid_q;
	logic [NODE_W-1:0]  evicted_node_q;
	logic [TOTAL_W-1:0] entry_total_q;
	logic               last_q;

	logic [ID_BITS+NODE_W-1:0]  id_wide;
	logic [ID_BITS-1:0]         id_in;
	logic [MW-1:0]              me_ext;
	logic [MW-1:0]              cap_ext;
	logic [MW-1:0]              limit;
	logic [MW-1:0]              count_ext;
	logic                       active;
	logic [SLOTS-1:0]           hit;
	logic                       any_hit;
	logic [SLOTS-1:0]           shift_en;
	logic [CW-1:0]              tail_cnt;
	logic [IW-1:0]              tail_idx;
	logic [ID_BITS-1:0]         tail_tag;
	logic [ID_BITS+NODE_W-1:0]  tail_wide;
	logic [CW+TOTAL_W-1:0]      cnt_dec_wide;
	logic [CW+TOTAL_W-1:0]      cnt_wide;
	logic                       out_free;

	assign id_wide = {{ID_BITS{1'b0}}, node_id};
	assign id_in   = id_wide[ID_BITS-1:0];

	// limit = min(max_entries, CAPACITY)
	assign me_ext    = MW'(max_entries_q);
	assign cap_ext   = MW'(CAPACITY);
	assign limit     = (me_ext > cap_ext) ? cap_ext : me_ext;
	assign count_ext = MW'(count_q);
	assign active    = (limit != '0) || (count_q != '0);

	// match in every listed cell
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit[i] = (CW'(i) < count_q) && (tag_q[i] == id_q);
		end
	end
	assign any_hit = |hit;

	// a cell shifts down when no hit sits in front of it
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			shift_en[i] = ~|(hit & (SLOTS'({SLOTS{1'b1}} >> (SLOTS - i))));
		end
	end

	assign tail_cnt  = count_q - CW'(1);
	assign tail_idx  = tail_cnt[IW-1:0];
	assign tail_tag  = tag_q[tail_idx];
	assign tail_wide = {{NODE_W{1'b0}}, tail_tag};

	assign cnt_dec_wide = {{TOTAL_W{1'b0}}, tail_cnt};
	assign cnt_wide     = {{TOTAL_W{1'b0}}, count_q};

	assign out_free = !out_valid_q || !out_stall;

	assign sts.out_free   = out_free;
	assign sts.over_limit = count_ext > limit;
	assign sts.last_evict = count_ext <= (limit + MW'(1));

	// list cells, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_id) begin
			id_q <= id_in;
		end
		if (cmd.touch && active) begin
			tag_q[0] <= id_q;
			for (int i = 1; i < SLOTS; i++) begin
				if (shift_en[i]) tag_q[i] <= tag_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			max_entries_q <= MAX_ENTRIES_RST;
			nref_q        <= 1'b0;
		end else begin
			if (cfg_write) begin
				max_entries_q <= cfg_data;
			end
			if (cmd.touch) begin
				nref_q <= active && !any_hit;
				if (active && !any_hit) count_q <= count_q + CW'(1);
			end else if (cmd.evict) begin
				count_q <= tail_cnt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.evict || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.evict) begin
			nref_out_q     <= nref_q;
			evict_valid_q  <= 1'b1;
			evicted_node_q <= tail_wide[NODE_W-1:0];
			entry_total_q  <= cnt_dec_wide[TOTAL_W-1:0];
			last_q         <= sts.last_evict;
		end else if (cmd.emit_final) begin
			nref_out_q     <= nref_q;
			evict_valid_q  <= 1'b0;
			evicted_node_q <= '0;
			entry_total_q  <= cnt_wide[TOTAL_W-1:0];
			last_q         <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign newly_referenced = nref_out_q;
	assign evict_valid      = evict_valid_q;
	assign evicted_node     = evicted_node_q;
	assign entry_total      = entry_total_q;
	assign last             = last_q;

endmodule : lnc_dpath

`default_nettype wire

/* rtl/lru_node_cache_unit.sv */
`default_nettype none

// LRU node cache: keeps a recency-ordered list of node ids, most recent first.
// Each input beat touches one node_id: a listed id moves to the front, a new id
// is added at the front with newly_referenced set. The list is then trimmed
// from its least recent end down to min(max_entries, CAPACITY), one output
// beat per dropped id (evict_valid=1); with nothing dropped a single beat with
// evict_valid=0 goes out. last marks the final beat of each input. With the
// limit at 0 and the list empty the touch is ignored and one all-zero beat
// with last=1 results. Each input passes a touch state (compare against every
// cell and shift of the cell chain), then the trim state sends one output
// beat per cycle while out_stall lets the output register take it; out_stall
// holds the trim state, and the touch state never overlaps any trim beats.
// A new beat is taken in the cycle the final output beat is loaded, and a
// waiting output beat sits in its register while the next item is taken.
// cfg_write loads max_entries (reset 16); write it only while idle. Ids wider
// than ID_BITS are cut to their low ID_BITS bits before matching.
module lru_node_cache_unit #(
	parameter int unsigned CAPACITY = 16,  // 1..64
	parameter int unsigned ID_BITS  = 16   // 4..64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_write,
	input  wire logic [lnc_pkg::LIMIT_W-1:0]  cfg_data,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [lnc_pkg::NODE_W-1:0]   node_id,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              newly_referenced,
	output logic                              evict_valid,
	output logic [lnc_pkg::NODE_W-1:0]        evicted_node,
	output logic [lnc_pkg::TOTAL_W-1:0]       entry_total,
	output logic                              last
);
	import lnc_pkg::*;

	lnc_cmd_t cmd;
	lnc_sts_t sts;

	// sequencer: idle -> touch -> trim (one beat per cycle while out_stall lets the output register take it)
	lnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// cell chain, entry count, limit register and output register
	lnc_dpath #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_data         (cfg_data),
		.node_id          (node_id),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.newly_referenced (newly_referenced),
		.evict_valid      (evict_valid),
		.evicted_node     (evicted_node),
		.entry_total      (entry_total),
		.last             (last),
		.cmd              (cmd),
		.sts              (sts)
	);

endmodule : lru_node_cache_unit

`default_nettype wire
